// ===== sv/rlff_pkg.sv =====
// Shared types and codes of the first-fit rectangle layering block.
package rlff_pkg;

   // Capacity of the rectangle store; the response field widths are sized for these.
   localparam int MAX_LAYERS      = 8;
   localparam int SLOTS_PER_LAYER = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAYER,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   // Result status codes.
   localparam logic [1:0] STATUS_PLACED  = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic load;        // capture the request
      logic read;        // read the stored rectangle at the scan position
      logic next_slot;   // step to the next slot of the current layer
      logic next_layer;  // step to slot 0 of the next layer
      logic commit;      // decide, store and load the response register
   } cmd_type;

   typedef struct packed {
      logic past_end;    // scan position is beyond the layers in use
      logic layer_empty; // current layer holds no rectangle
      logic overlap;     // fetched rectangle overlaps the request
      logic last_slot;   // fetched rectangle is the last one of its layer
      logic rsp_free;    // response register can take a new result
   } status_type;

endpackage

// ===== sv/rlff_ctrl.sv =====
// Controller state machine that sequences the layer scan.
module rlff_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rlff_pkg::status_type stat,
   output rlff_pkg::cmd_type    cmd
);
   import rlff_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LAYER;
            end
         end
         ST_LAYER: begin
            // An empty layer fits at once; past the last layer in use a new layer is opened if one is free.
            if (stat.past_end || stat.layer_empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (stat.overlap) begin
               cmd.next_layer = 1'b1;
               state_in       = ST_LAYER;
            end else if (stat.last_slot) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_slot = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/rlff_dp.sv =====
// Datapath: rectangle memory, layer fill counts, overlap test and response register.
module rlff_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [63:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   input  rlff_pkg::cmd_type    cmd,
   output rlff_pkg::status_type stat
);
   import rlff_pkg::*;

   localparam int DEPTH = MAX_LAYERS * SLOTS_PER_LAYER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LCW   = $clog2(MAX_LAYERS + 1);
   localparam int SW    = (SLOTS_PER_LAYER > 1) ? $clog2(SLOTS_PER_LAYER) : 1;
   localparam int FW    = $clog2(SLOTS_PER_LAYER + 1);

   logic [63:0]    mem [DEPTH];
   logic [63:0]    rd_data_ff;
   logic [63:0]    item_ff;
   logic [FW-1:0]  fill_ff [MAX_LAYERS];
   logic [LCW-1:0] used_ff;
   logic [LCW-1:0] layer_ff;
   logic [LCW-1:0] layer_in;
   logic [SW-1:0]  slot_ff;
   logic [SW-1:0]  slot_in;
   logic           rsp_valid_ff;
   logic [15:0]    rsp_data_ff;

   logic [LW-1:0]  layer_idx;
   logic [FW-1:0]  fill_cur;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic           fitted;
   logic           place;
   logic [1:0]     status_code;
   logic [2:0]     report_layer;
   logic [LCW-1:0] used_next;

   // Doubled-coordinate edges, wide enough for 2*center +/- size.
   logic signed [17:0] a_xlo, a_xhi, a_ylo, a_yhi;
   logic signed [17:0] b_xlo, b_xhi, b_ylo, b_yhi;

   assign layer_idx = layer_ff[LW-1:0];
   assign fill_cur  = (layer_ff < LCW'(MAX_LAYERS)) ? fill_ff[layer_idx] : '0;
   assign rd_addr   = AW'(int'(layer_idx) * SLOTS_PER_LAYER + int'(slot_ff));
   assign wr_addr   = AW'(int'(layer_idx) * SLOTS_PER_LAYER + int'(fill_cur));

   always_comb begin
      a_xlo = {item_ff[15], item_ff[15:0], 1'b0} - {2'b00, item_ff[47:32]};
      a_xhi = {item_ff[15], item_ff[15:0], 1'b0} + {2'b00, item_ff[47:32]};
      a_ylo = {item_ff[31], item_ff[31:16], 1'b0} - {2'b00, item_ff[63:48]};
      a_yhi = {item_ff[31], item_ff[31:16], 1'b0} + {2'b00, item_ff[63:48]};
      b_xlo = {rd_data_ff[15], rd_data_ff[15:0], 1'b0} - {2'b00, rd_data_ff[47:32]};
      b_xhi = {rd_data_ff[15], rd_data_ff[15:0], 1'b0} + {2'b00, rd_data_ff[47:32]};
      b_ylo = {rd_data_ff[31], rd_data_ff[31:16], 1'b0} - {2'b00, rd_data_ff[63:48]};
      b_yhi = {rd_data_ff[31], rd_data_ff[31:16], 1'b0} + {2'b00, rd_data_ff[63:48]};
   end

   always_comb begin
      stat.overlap     = (a_xlo < b_xhi) && (a_xhi > b_xlo)
                         && (a_yhi > b_ylo) && (a_ylo < b_yhi);
      stat.past_end    = (layer_ff >= used_ff);
      stat.layer_empty = (fill_cur == '0);
      stat.last_slot   = ((FW'(slot_ff) + FW'(1)) == fill_cur);
      stat.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   // The scan stops at the first layer with no overlapping rectangle, or one past the last layer in use.
   // In the second case that position is exactly the layer a new rectangle opens.
   always_comb begin
      fitted       = (layer_ff < used_ff);
      place        = 1'b0;
      status_code  = STATUS_PLACED;
      report_layer = 3'(layer_ff);
      used_next    = used_ff;
      if (fitted) begin
         if (fill_cur >= FW'(SLOTS_PER_LAYER)) begin
            status_code = STATUS_FULL;
         end else begin
            place = 1'b1;
         end
      end else if (used_ff >= LCW'(MAX_LAYERS)) begin
         status_code  = STATUS_NO_FREE;
         report_layer = 3'd0;
      end else begin
         place     = 1'b1;
         used_next = used_ff + LCW'(1);
      end
   end

   always_comb begin
      layer_in = layer_ff;
      slot_in  = slot_ff;
      if (cmd.load) begin
         layer_in = '0;
         slot_in  = '0;
      end else if (cmd.next_layer) begin
         layer_in = layer_ff + LCW'(1);
         slot_in  = '0;
      end else if (cmd.next_slot) begin
         slot_in = slot_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.commit && place) begin
         mem[wr_addr] <= item_ff;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff <= layer_in;
      slot_ff  <= slot_in;
      if (cmd.load) begin
         item_ff <= req_tdata;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {2'b00, status_code, 4'(used_next),
                         place && !fitted, place ? 4'(fill_cur) : 4'd0, report_layer};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         if (cmd.commit) begin
            used_ff <= used_next;
            if (place) begin
               fill_ff[layer_idx] <= fill_cur + FW'(1);
            end
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/rect_layer_first_fit_core.sv =====
// Top level of the first-fit rectangle layering block.
//
//  Channel  Direction  Payload
//  req_*    in         tdata[63:0] = center_x, center_y, rect_width, rect_height
//  rsp_*    out        tdata[15:0] = layer_index, slot_index, opened_layer,
//                                    layer_total, status, zero pad
//
// After a request is accepted the scan steps through the layers in order (the stop one
// past the last layer in use counts as a layer step) and compares the stored rectangles
// of each layer one at a time; the single-port rectangle memory is read once per compare
// and the overlap test uses the registered read data. Reset is synchronous and clears the
// layer count and all fill counts; the memory needs no clearing. A new request is taken
// while a result waits in the response register; the scan then holds in its last step
// until that register frees up.
module rect_layer_first_fit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // center_x, center_y, rect_width, rect_height
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // layer_index, slot_index, opened_layer,
                                   // layer_total, status, pad
);
   import rlff_pkg::*;

   cmd_type    cmd;
   status_type stat;

   rlff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rlff_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
